// File: hw/rtl/peer_keepalive_timer_scan_assert.svh
// assertion macros for the keepalive timer scan
`ifndef PEER_KEEPALIVE_TIMER_SCAN_ASSERT_SVH
`define PEER_KEEPALIVE_TIMER_SCAN_ASSERT_SVH

// property that must hold whenever not in reset
`define PKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/pka_pkg.sv
// package with types and constants for the keepalive timer scan
package pka_pkg;
  localparam int NumPeers = 32;
  localparam int IdxW = $clog2(NumPeers);
  localparam int TimeW = 48;
  localparam int DelayW = 36;
  localparam int TolW = 20;
  localparam int IvlW = 16;
  localparam logic [TolW-1:0] TolReset = 20'd100000;
  localparam logic [19:0] UsPerS = 20'd1000000;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ENABLE = 2'd1,
    OP_DISABLE = 2'd2,
    OP_SET_IVL = 2'd3
  } op_t;

  localparam logic [0:0] KIND_DUE = 1'b0;
  localparam logic [0:0] KIND_END = 1'b1;
  localparam logic [0:0] REG_TOLERANCE = 1'b0;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] peer_index;
    logic [IvlW-1:0] interval_s;
    logic [TimeW-1:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic kind;
    logic [4:0] due_peer;
    logic [DelayW-1:0] next_delay_us;
    logic last_of_run;
  } out_word_t;
endpackage

// File: hw/rtl/pka_if.sv
// valid/ready channel interfaces
interface pka_in_if (input logic clk);
  import pka_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [4:0] peer_index;
  logic [IvlW-1:0] interval_s;
  logic [TimeW-1:0] now_us;
  modport source (output valid, op, peer_index, interval_s, now_us, input ready);
  modport sink (input valid, op, peer_index, interval_s, now_us, output ready);
endinterface

interface pka_out_if (input logic clk);
  import pka_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  logic [4:0] due_peer;
  logic [DelayW-1:0] next_delay_us;
  logic last_of_run;
  modport source (output valid, kind, due_peer, next_delay_us, last_of_run, input ready);
  modport sink (input valid, kind, due_peer, next_delay_us, last_of_run, output ready);
endinterface

// File: hw/rtl/pka_ram.sv
// generic single-port-write ram with registered read
module pka_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/pka_front.sv
// front end: input word queue feeding the scan engine
module pka_front (
  input  logic              clk,
  input  logic              rst,
  pka_in_if.sink            in_ch,
  output pka_pkg::in_word_t q_word,
  output logic              q_valid,
  input  logic              q_pop
);
  import pka_pkg::*;
  localparam int Depth = 2;
  in_word_t buf_q [Depth];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign q_word = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= '{op: in_ch.op, peer_index: in_ch.peer_index,
                         interval_s: in_ch.interval_s, now_us: in_ch.now_us};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end
endmodule

// File: hw/rtl/pka_back.sv
// back end: peer table update and tick scan
`include "peer_keepalive_timer_scan_assert.svh"
module pka_back (
  input  logic                    clk,
  input  logic                    rst,
  input  pka_pkg::in_word_t       q_word,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [pka_pkg::TolW-1:0] tolerance,
  pka_out_if.source               out_ch
);
  import pka_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_CMP, S_EMIT, S_NEXT, S_END} state_t;
  state_t state;
  logic [NumPeers-1:0] active;
  logic [IdxW-1:0] idx;
  logic [TimeW-1:0] now;
  logic [DelayW-1:0] best;
  logic have;
  logic [DelayW-1:0] ka;
  logic [TimeW-1:0] elapsed;
  logic due;
  logic [DelayW-1:0] delay;
  logic [IvlW-1:0] ivl_rd;
  logic [TimeW-1:0] last_rd;
  logic ivl_we, last_we;
  logic [IdxW-1:0] waddr;
  logic [IvlW-1:0] ivl_wd;
  logic [TimeW-1:0] last_wd;
  logic out_busy;
  logic is_cfg;
  logic [TimeW-1:0] ka_w;

  assign out_busy = out_ch.valid && !out_ch.ready;
  assign is_cfg = q_word.op != OP_TICK;
  assign q_pop = (state == S_IDLE && q_valid && is_cfg) || (state == S_END && !out_busy);

  always_comb begin
    ivl_we = 1'b0;
    last_we = 1'b0;
    waddr = q_word.peer_index[IdxW-1:0];
    ivl_wd = q_word.interval_s;
    last_wd = q_word.now_us;
    if (state == S_IDLE && q_valid && is_cfg && 32'(q_word.peer_index) < NumPeers) begin
      if (q_word.op == OP_ENABLE && !active[q_word.peer_index[IdxW-1:0]]) begin
        ivl_we = 1'b1;
        last_we = 1'b1;
      end else if (q_word.op == OP_SET_IVL) begin
        ivl_we = 1'b1;
      end
    end
    if (state == S_EMIT && due) begin
      waddr = idx;
      last_wd = now;
      last_we = 1'b1;
    end
  end

  pka_ram #(.Width(IvlW), .Depth(NumPeers)) u_ivl (
    .clk, .we(ivl_we), .waddr, .wdata(ivl_wd), .raddr(idx), .rdata(ivl_rd));
  pka_ram #(.Width(TimeW), .Depth(NumPeers)) u_last (
    .clk, .we(last_we), .waddr, .wdata(last_wd), .raddr(idx), .rdata(last_rd));

  assign ka_w = TimeW'(ka);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      idx <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (is_cfg) begin
              if (32'(q_word.peer_index) < NumPeers) begin
                if (q_word.op == OP_ENABLE) active[q_word.peer_index[IdxW-1:0]] <= 1'b1;
                if (q_word.op == OP_DISABLE) active[q_word.peer_index[IdxW-1:0]] <= 1'b0;
              end
            end else begin
              idx <= '0;
              now <= q_word.now_us;
              have <= 1'b0;
              best <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_MUL;
        S_MUL: begin
          ka <= DelayW'(ivl_rd) * DelayW'(UsPerS);
          elapsed <= now - last_rd;
          if (active[idx] && ivl_rd != '0) state <= S_CMP;
          else state <= S_NEXT;
        end
        S_CMP: begin
          if (elapsed >= ka_w) begin
            due <= 1'b1;
            delay <= ka;
          end else begin
            due <= (ka_w - elapsed) < TimeW'(tolerance);
            delay <= ((ka_w - elapsed) < TimeW'(tolerance)) ? ka : DelayW'(ka_w - elapsed);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_busy) begin
            if (due) begin
              out_ch.valid <= 1'b1;
              out_ch.kind <= KIND_DUE;
              out_ch.due_peer <= 5'(idx);
              out_ch.next_delay_us <= '0;
              out_ch.last_of_run <= 1'b0;
            end
            if (!have || delay < best) best <= delay;
            have <= 1'b1;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (32'(idx) == NumPeers - 1) state <= S_END;
          else begin
            idx <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_END: begin
          if (!out_busy) begin
            out_ch.valid <= 1'b1;
            out_ch.kind <= KIND_END;
            out_ch.due_peer <= '0;
            out_ch.next_delay_us <= best;
            out_ch.last_of_run <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PKS_ASSERT(a_end_last, !out_ch.valid || (out_ch.kind == out_ch.last_of_run), "kind and last differ")
  `PKS_ASSERT(a_due_zero, !out_ch.valid || out_ch.kind || out_ch.next_delay_us == '0, "due word delay")
  `PKS_ASSERT_NEXT(a_end_idle, state == S_END && !out_busy, state == S_IDLE && out_ch.valid, "end lost")
endmodule

// File: hw/rtl/peer_keepalive_timer_scan.sv
// a tick visits every slot: read, multiply, then compare and emit if active with nonzero interval, then next
// output stalls hold the scan in the emit state and in the end state
// peer updates pass through the input queue and are applied by the back end in its idle state
// results leave one by one through an output register; a 2-word queue decouples input
// synchronous active-high reset clears the active bits and sets tolerance to 100000
// interval and last-sent tables are not cleared by reset
module peer_keepalive_timer_scan (
  input  logic                      clk,
  input  logic                      rst,
  pka_in_if.sink                    in_ch,
  pka_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import pka_pkg::*;
  logic [TolW-1:0] tolerance;
  in_word_t q_word;
  logic q_valid, q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(tolerance) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) tolerance <= TolReset;
    else if (psel && penable && pwrite && paddr[1:0] == {REG_TOLERANCE, 1'b0})
      tolerance <= pwdata[TolW-1:0];
  end

  pka_front u_front (.clk, .rst, .in_ch, .q_word, .q_valid, .q_pop);
  pka_back u_back (.clk, .rst, .q_word, .q_valid, .q_pop, .tolerance, .out_ch);
endmodule
